// File: hw/rtl/mphd_pkg.sv
// shared types and constants for the multi-pin history debouncer
// no dependencies; used by mphd_ring, multi_pin_history_debouncer_top and the bench
`timescale 1ns / 1ps
`default_nettype none

package mphd_pkg;

	localparam int NUM_PINS_DEF      = 16;
	localparam int HISTORY_DEPTH_DEF = 10;

	// fixed field widths
	localparam int LEVELS_W = 16;
	localparam int INDEX_W  = 4;
	localparam int LEN_W    = 4;
	localparam int CFG_W    = 64;
	localparam int ADDR_W   = 2;
	localparam int OUT_W    = 8;

	// configuration register indexes
	typedef enum logic [ADDR_W-1:0] {
		CFG_PIN_ENABLE = 2'd0,
		CFG_FILTER_LEN = 2'd1
	} cfg_addr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_EMIT
	} state_t;

	// sequencer commands to the sample ring
	typedef struct packed {
		logic prime;  // fill every slot with the sample
		logic push;   // write the next slot and aim the read pointer behind it
		logic step;   // move the read pointer one slot further back
	} ring_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/mphd_ring.sv
// sample history ring: storage, write pointer and a backward-walking read pointer
// depends on mphd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mphd_ring #(
	parameter int NUM_PINS      = mphd_pkg::NUM_PINS_DEF,
	parameter int HISTORY_DEPTH = mphd_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mphd_pkg::ring_ctrl_t ctrl,
	input  wire logic [NUM_PINS-1:0]  sample,
	output logic      [NUM_PINS-1:0]  rd_data
);

	localparam int PW = $clog2(HISTORY_DEPTH);
	localparam logic [PW-1:0] LAST_SLOT = PW'(HISTORY_DEPTH - 1);

	logic [NUM_PINS-1:0] ring_q [HISTORY_DEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_slot_q;
	logic [PW-1:0]       wr_back;
	logic [PW-1:0]       rd_back;

	assign wr_back = (wr_ptr_q == '0) ? LAST_SLOT : wr_ptr_q - 1'b1;
	assign rd_back = (rd_slot_q == '0) ? LAST_SLOT : rd_slot_q - 1'b1;
	assign rd_data = ring_q[rd_slot_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_slot_q <= '0;
		end else if (ctrl.prime) begin
			wr_ptr_q <= '0;
		end else if (ctrl.push) begin
			wr_ptr_q  <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			rd_slot_q <= wr_back;
		end else if (ctrl.step) begin
			rd_slot_q <= rd_back;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.prime) begin
			for (int k = 0; k < HISTORY_DEPTH; k++) begin
				ring_q[k] <= sample;
			end
		end else if (ctrl.push) begin
			ring_q[wr_ptr_q] <= sample;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/multi_pin_history_debouncer_top.sv
// multi-pin debouncer with a short sample history, top level
// depends on mphd_pkg and mphd_ring
//
// usage: each word on s_* is one periodic sample of all pin levels (bit i is
// pin i). the first word after reset primes the history and the stable levels
// and gives no results. every later word is written to the ring, then the
// history is walked back over all older slots one slot per cycle, all pins
// compared in parallel. after that the changed pins are sent on m_*, one word
// per cycle while the receiver keeps up, in ascending pin order, the final one
// flagged; a sample with no changes sends no word. the walk is sequential, set
// by the single ring read port, and every word passes the single output
// register; s_tready is low while a sample is walked or emitted.
// a stalled receiver holds m_* in the output register and pauses the emit
// sequence; the next sample is taken while the final word still waits.
// configuration is written through cfg_we/cfg_addr/cfg_wdata; the user must
// write it only while idle, the block itself does not enforce this.
// reset (arst_n low) clears the enables, filter lengths, stable levels, the
// primed flag and the output; the history itself is refilled by priming.
`timescale 1ns / 1ps
`default_nettype none

module multi_pin_history_debouncer_top #(
	parameter int NUM_PINS      = mphd_pkg::NUM_PINS_DEF,
	parameter int HISTORY_DEPTH = mphd_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [mphd_pkg::LEVELS_W-1:0] s_tdata,   // [15:0] pin_levels
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [3:0] pin_index, [4] new_level, [5] last_change, [7:6] zero
	output logic      [mphd_pkg::OUT_W-1:0]    m_tdata,
	input  wire logic                          cfg_we,
	input  wire logic [mphd_pkg::ADDR_W-1:0]   cfg_addr,
	input  wire logic [mphd_pkg::CFG_W-1:0]    cfg_wdata
);

	localparam int PW = $clog2(HISTORY_DEPTH);
	localparam int LW = mphd_pkg::LEN_W;
	localparam int IW = mphd_pkg::INDEX_W;
	localparam logic [PW-1:0] LAST_STEP = PW'(HISTORY_DEPTH - 1);

	mphd_pkg::state_t     state_q, state_nx;
	mphd_pkg::ring_ctrl_t ring_ctrl;

	logic [NUM_PINS-1:0]    enable_q;
	logic [LW*NUM_PINS-1:0] filter_q;
	logic [NUM_PINS-1:0]    stable_q;
	logic                   primed_q;
	logic [NUM_PINS-1:0]    sample_q;
	logic [NUM_PINS-1:0]    agree_q, agree_nx;
	logic [NUM_PINS-1:0]    pend_q, pend_rest, change;
	logic [PW-1:0]          step_q;
	logic [NUM_PINS-1:0]    rd_data;
	logic [NUM_PINS-1:0]    sample_in;

	logic          out_valid_q;
	logic [IW-1:0] out_idx_q, lo_idx;
	logic          out_level_q, out_last_q;

	logic accept, last_step, load;

	assign sample_in = s_tdata[NUM_PINS-1:0];
	assign accept    = s_tvalid && s_tready;
	assign last_step = (step_q == LAST_STEP);

	mphd_ring #(
		.NUM_PINS      (NUM_PINS),
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ring_ctrl),
		.sample  (sample_in),
		.rd_data (rd_data)
	);

	// a pin keeps agreeing while the slot is beyond its filter length or matches
	always_comb begin
		for (int p = 0; p < NUM_PINS; p++) begin
			agree_nx[p] = agree_q[p] &&
				((filter_q[LW*p +: LW] < LW'(step_q)) || (rd_data[p] == sample_q[p]));
		end
	end

	assign change    = enable_q & agree_nx & (sample_q ^ stable_q);
	assign pend_rest = pend_q & (pend_q - 1'b1);

	always_comb begin
		lo_idx = '0;
		for (int i = NUM_PINS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				lo_idx = IW'(i);
			end
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			mphd_pkg::ST_IDLE: begin
				if (accept && primed_q) begin
					state_nx = mphd_pkg::ST_CMP;
				end
			end
			mphd_pkg::ST_CMP: begin
				if (last_step) begin
					state_nx = mphd_pkg::ST_EMIT;
				end
			end
			mphd_pkg::ST_EMIT: begin
				if ((pend_q == '0) || (load && (pend_rest == '0))) begin
					state_nx = mphd_pkg::ST_IDLE;
				end
			end
			default: state_nx = mphd_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready        = 1'b0;
		ring_ctrl       = '0;
		load            = 1'b0;
		case (state_q)
			mphd_pkg::ST_IDLE: begin
				s_tready        = 1'b1;
				ring_ctrl.prime = s_tvalid && !primed_q;
				ring_ctrl.push  = s_tvalid && primed_q;
			end
			mphd_pkg::ST_CMP: begin
				ring_ctrl.step = 1'b1;
			end
			mphd_pkg::ST_EMIT: begin
				load = (pend_q != '0) && (!out_valid_q || m_tready);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mphd_pkg::ST_IDLE;
			enable_q <= '0;
			filter_q <= '0;
			stable_q <= '0;
			primed_q <= 1'b0;
			pend_q   <= '0;
			step_q   <= '0;
			agree_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				case (cfg_addr)
					mphd_pkg::CFG_PIN_ENABLE: enable_q <= cfg_wdata[NUM_PINS-1:0];
					mphd_pkg::CFG_FILTER_LEN: filter_q <= cfg_wdata[LW*NUM_PINS-1:0];
					default: ;
				endcase
			end
			if (ring_ctrl.prime) begin
				stable_q <= sample_in;
				primed_q <= 1'b1;
			end
			if (ring_ctrl.push) begin
				agree_q <= '1;
				step_q  <= PW'(1);
			end
			if (ring_ctrl.step) begin
				agree_q <= agree_nx;
				step_q  <= step_q + 1'b1;
				if (last_step) begin
					pend_q   <= change;
					stable_q <= stable_q ^ change;
				end
			end
			if (load) begin
				pend_q      <= pend_rest;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ring_ctrl.push) begin
			sample_q <= sample_in;
		end
		if (load) begin
			out_idx_q   <= lo_idx;
			out_level_q <= sample_q[lo_idx];
			out_last_q  <= (pend_rest == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_last_q, out_level_q, out_idx_q};

	a_pend_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mphd_pkg::ST_IDLE) |-> (pend_q == '0))
		else $error("pending changes left over while idle");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mphd_pkg::ST_CMP) |-> ((step_q != '0) && (step_q <= LAST_STEP)))
		else $error("history step out of range");

	a_primed_enters_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && primed_q) |=> (state_q == mphd_pkg::ST_CMP))
		else $error("sample accepted but compare walk not started");

	a_prime_no_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !primed_q) |=> (primed_q && (state_q == mphd_pkg::ST_IDLE)))
		else $error("priming sample did not complete in one cycle");

	a_load_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid_q || m_tready))
		else $error("output word overwritten before taken");

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for multi_pin_history_debouncer_top: directed table, then bouncing samples
// depends on mphd_pkg and the debouncer rtl; a behavioural model predicts all but typed-row changes

module tb;

	localparam int DEPTH          = mphd_pkg::HISTORY_DEPTH_DEF;
	localparam int PINS           = mphd_pkg::NUM_PINS_DEF;
	localparam int SETTLE_CYCLES  = 24;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_PRINTS     = 200;
	localparam int NUM_ROWS       = 29;

	// indexes past the register list, writes there must do nothing
	localparam logic [mphd_pkg::ADDR_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [mphd_pkg::ADDR_W-1:0] CFG_SPARE_B = 2'd3;

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_SAMPLE,
		ROW_SAMPLE_TYPED
	} row_kind_t;

	typedef struct packed {
		row_kind_t                         kind;
		logic [mphd_pkg::ADDR_W-1:0]       addr;
		logic [mphd_pkg::CFG_W-1:0]        value;
		logic [mphd_pkg::LEVELS_W-1:0]     levels;
		logic                              has_change;
		logic [mphd_pkg::INDEX_W-1:0]      pin;
		logic                              level;
	} row_t;

	typedef struct packed {
		logic [mphd_pkg::INDEX_W-1:0] pin;
		logic                         level;
		logic                         is_last;
	} change_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [mphd_pkg::LEVELS_W-1:0] s_tdata   = '0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [mphd_pkg::OUT_W-1:0]    m_tdata;
	logic                          cfg_we    = 1'b0;
	logic [mphd_pkg::ADDR_W-1:0]   cfg_addr  = '0;
	logic [mphd_pkg::CFG_W-1:0]    cfg_wdata = '0;

	// debounce model state
	logic [mphd_pkg::LEVELS_W-1:0] hist [DEPTH];
	int                            wr_slot   = 0;
	logic [mphd_pkg::LEVELS_W-1:0] settled   = '0;
	bit                            primed_q  = 1'b0;
	logic [mphd_pkg::LEVELS_W-1:0] en_mask   = '0;
	logic [mphd_pkg::CFG_W-1:0]    flt_len   = '0;
	change_t                       change_q [$];

	int                            errors       = 0;
	int                            prints       = 0;
	int                            tx_idle_pct  = 0;
	int                            rx_stall_pct = 0;
	bit                            hold_on      = 1'b0;
	int                            hold_cnt     = 0;
	int                            idle_cycles  = 0;
	logic [mphd_pkg::LEVELS_W-1:0] target       = '0;
	change_t                       want_chg;
	row_t                          dir_rows [NUM_ROWS];

	multi_pin_history_debouncer_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // [15:0] pin_levels
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),    // [3:0] pin_index, [4] new_level, [5] last_change
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		errors++;
		if (prints < MAX_PRINTS) begin
			$display("%0t mismatch: %s", $time, what);
			prints++;
		end
	endtask

	task automatic debounce_sample(input logic [mphd_pkg::LEVELS_W-1:0] smp, input bit record);
		int      end_slot;
		int      slot;
		int      len;
		int      p;
		int      i;
		logic    cur;
		logic    nxt;
		change_t chg;
		change_t batch [$];
		if (!primed_q) begin
			for (i = 0; i < DEPTH; i++) hist[i] = smp;
			settled  = smp;
			wr_slot  = 0;
			primed_q = 1'b1;
			return;
		end
		end_slot       = wr_slot;
		hist[end_slot] = smp;
		wr_slot        = (end_slot == DEPTH - 1) ? 0 : end_slot + 1;
		for (p = 0; p < PINS; p++) begin
			if (!en_mask[p]) continue;
			cur = settled[p];
			nxt = smp[p];
			len = int'(flt_len[4*p +: 4]);
			if (len > DEPTH) len = DEPTH;
			// walk back from the new word; any disagreement keeps the old level
			slot = end_slot;
			for (i = 0; i < len; i++) begin
				slot = (slot == 0) ? DEPTH - 1 : slot - 1;
				if (hist[slot][p] != nxt) begin
					nxt = cur;
					break;
				end
			end
			if (nxt != cur) begin
				chg.pin     = p[mphd_pkg::INDEX_W-1:0];
				chg.level   = nxt;
				chg.is_last = 1'b0;
				batch.push_back(chg);
				settled[p] = nxt;
			end
		end
		if (batch.size() != 0) batch[batch.size()-1].is_last = 1'b1;
		if (record) foreach (batch[k]) change_q.push_back(batch[k]);
	endtask

	task automatic send_sample(input logic [mphd_pkg::LEVELS_W-1:0] lv);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= lv;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// drain every pending change, then let a word with no changes finish too
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (change_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [mphd_pkg::ADDR_W-1:0] a,
			input logic [mphd_pkg::CFG_W-1:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_addr  <= a;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (a)
			mphd_pkg::CFG_PIN_ENABLE: en_mask = v[mphd_pkg::LEVELS_W-1:0];
			mphd_pkg::CFG_FILTER_LEN: flt_len = v;
			default: ;
		endcase
	endtask

	// mostly a slowly moving level pattern with the odd bounce, some plain noise
	task automatic make_sample(output logic [mphd_pkg::LEVELS_W-1:0] smp);
		int b;
		if ($urandom_range(9) == 0) begin
			smp = mphd_pkg::LEVELS_W'($urandom);
			return;
		end
		for (b = 0; b < mphd_pkg::LEVELS_W; b++) begin
			if ($urandom_range(13) == 0) target[b] = ~target[b];
		end
		smp = target;
		if ($urandom_range(2) == 0) begin
			b      = $urandom_range(mphd_pkg::LEVELS_W - 1);
			smp[b] = ~smp[b];
		end
	endtask

	task automatic random_setup();
		logic [mphd_pkg::LEVELS_W-1:0] en;
		logic [mphd_pkg::CFG_W-1:0]    lens;
		int                            p;
		int                            r;
		en = ($urandom_range(3) == 0) ? '1 : mphd_pkg::LEVELS_W'($urandom);
		for (p = 0; p < PINS; p++) begin
			r = $urandom_range(99);
			if (r < 50) lens[4*p +: 4] = mphd_pkg::LEN_W'($urandom_range(3));
			else if (r < 80) lens[4*p +: 4] = mphd_pkg::LEN_W'($urandom_range(9, 4));
			else lens[4*p +: 4] = mphd_pkg::LEN_W'($urandom_range(15, 10));
		end
		set_reg(mphd_pkg::CFG_PIN_ENABLE, mphd_pkg::CFG_W'(en));
		set_reg(mphd_pkg::CFG_FILTER_LEN, lens);
	endtask

	task automatic run_phase(input int n, input int tx_pct, input int rx_pct);
		logic [mphd_pkg::LEVELS_W-1:0] smp;
		rx_stall_pct <= rx_pct;
		tx_idle_pct = tx_pct;
		repeat (n) begin
			make_sample(smp);
			send_sample(smp);
			debounce_sample(smp, 1'b1);
		end
	endtask

	always @(posedge clk) begin
		if (hold_on && hold_cnt < HOLD_CYCLES) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
			if (!hold_on) hold_cnt <= 0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (change_q.size() == 0) begin
				report_mismatch($sformatf("change word %h with none pending", m_tdata));
			end else begin
				want_chg = change_q.pop_front();
				if (m_tdata[3:0] != want_chg.pin)
					report_mismatch($sformatf("pin_index %0d, want %0d",
						m_tdata[3:0], want_chg.pin));
				if (m_tdata[4] != want_chg.level)
					report_mismatch($sformatf("new_level %b on pin %0d, want %b",
						m_tdata[4], want_chg.pin, want_chg.level));
				if (m_tdata[5] != want_chg.is_last)
					report_mismatch($sformatf("last_change %b on pin %0d, want %b",
						m_tdata[5], want_chg.pin, want_chg.is_last));
				if (m_tdata[7:6] != 2'b00)
					report_mismatch($sformatf("pad bits %b, want 00", m_tdata[7:6]));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		row_t    row;
		change_t chg;
		int      r;
		dir_rows = '{
			// priming word fills the history, never reported
			'{ROW_SAMPLE_TYPED, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hA5A5, 1'b0, 4'd0, 1'b0},
			// all pins disabled out of reset
			'{ROW_SAMPLE_TYPED, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'h5A5A, 1'b0, 4'd0, 1'b0},
			'{ROW_WRITE, mphd_pkg::CFG_PIN_ENABLE, 64'h0000_0000_0000_FFFF, 16'h0000,
				1'b0, 4'd0, 1'b0},
			'{ROW_WRITE, mphd_pkg::CFG_FILTER_LEN, 64'd0, 16'h0000, 1'b0, 4'd0, 1'b0},
			// zero filter length, a lone flip on pin 0 is taken at once
			'{ROW_SAMPLE_TYPED, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hA5A4, 1'b1, 4'd0, 1'b0},
			'{ROW_SAMPLE_TYPED, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hA5A5, 1'b1, 4'd0, 1'b1},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'h5A5A, 1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hFFFF, 1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'h0000, 1'b0, 4'd0, 1'b0},
			// lengths above the history depth clamp
			'{ROW_WRITE, mphd_pkg::CFG_FILTER_LEN, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000,
				1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hFFFF, 1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hFFFF, 1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hFFFF, 1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hFFFF, 1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hFFFF, 1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hFFFF, 1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hFFFF, 1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hFFFF, 1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hFFFF, 1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hFFFF, 1'b0, 4'd0, 1'b0},
			'{ROW_WRITE, CFG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 1'b0, 4'd0, 1'b0},
			'{ROW_WRITE, CFG_SPARE_B, 64'd0, 16'h0000, 1'b0, 4'd0, 1'b0},
			'{ROW_WRITE, mphd_pkg::CFG_FILTER_LEN, 64'h0123_4567_89AB_CDEF, 16'h0000,
				1'b0, 4'd0, 1'b0},
			'{ROW_WRITE, mphd_pkg::CFG_PIN_ENABLE, 64'h0000_0000_0000_F0F3, 16'h0000,
				1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'h0000, 1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'h0000, 1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hFFFF, 1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'hFFFF, 1'b0, 4'd0, 1'b0},
			'{ROW_SAMPLE, mphd_pkg::CFG_PIN_ENABLE, 64'd0, 16'h00FF, 1'b0, 4'd0, 1'b0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < NUM_ROWS; r++) begin
			row = dir_rows[r];
			case (row.kind)
				ROW_WRITE: set_reg(row.addr, row.value);
				ROW_SAMPLE: begin
					send_sample(row.levels);
					debounce_sample(row.levels, 1'b1);
				end
				default: begin
					send_sample(row.levels);
					debounce_sample(row.levels, 1'b0);
					if (row.has_change) begin
						chg = '{row.pin, row.level, 1'b1};
						change_q.push_back(chg);
					end
				end
			endcase
		end

		// every pin live with no filtering, full rate both sides
		set_reg(mphd_pkg::CFG_PIN_ENABLE, 64'h0000_0000_0000_FFFF);
		set_reg(mphd_pkg::CFG_FILTER_LEN, 64'd0);
		run_phase(60, 0, 0);

		random_setup();
		run_phase(100, 61, 0);
		random_setup();
		run_phase(100, 0, 61);
		random_setup();
		run_phase(100, 16, 16);

		// receiver holds off while the sender keeps offering, so the input backs up
		set_reg(mphd_pkg::CFG_PIN_ENABLE, 64'h0000_0000_0000_FFFF);
		set_reg(mphd_pkg::CFG_FILTER_LEN, 64'd0);
		hold_on <= 1'b1;
		run_phase(50, 0, 0);
		hold_on <= 1'b0;

		// nothing enabled, longest filters: no words may appear
		set_reg(mphd_pkg::CFG_PIN_ENABLE, 64'd0);
		set_reg(mphd_pkg::CFG_FILTER_LEN, 64'hFFFF_FFFF_FFFF_FFFF);
		run_phase(15, 0, 0);

		wait_idle();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
